[design/cscc_pkg.sv]
`default_nettype none

package cscc_pkg;

    // Fixed field widths of the streaming and configuration beats.
    localparam int ADDR_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int MODE_W  = 2;
    localparam int LSTAT_W = 2;
    localparam int RES_W   = 8;

    typedef logic [FUNC_W-1:0]  func_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [LSTAT_W-1:0] lstat_t;

    // Line state codes.
    localparam lstat_t LS_INV = 2'd0;
    localparam lstat_t LS_VAL = 2'd1;
    localparam lstat_t LS_SHR = 2'd2;
    localparam lstat_t LS_MOD = 2'd3;

    // Access kinds.
    localparam func_t FN_LOAD   = 2'd0;
    localparam func_t FN_STORE  = 2'd1;
    localparam func_t FN_LDMISS = 2'd2;
    localparam func_t FN_STMISS = 2'd3;

    // Coherence modes.
    localparam mode_t MODE_NONE = 2'd0;
    localparam mode_t MODE_VI   = 2'd1;
    localparam mode_t MODE_MSI  = 2'd2;

    // Bit positions of the result flags in m_tdata.
    localparam int RES_HIT = 0;
    localparam int RES_WB  = 1;
    localparam int RES_UPG = 2;

endpackage

`default_nettype wire

[design/cscc_ram.sv]
`default_nettype none

module cscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/coherent_set_assoc_cache_ctrl.sv]
`default_nettype none
// Channel   Direction  Signals                          Beat contents
// s_*       in         s_tvalid/s_tready/s_tdata/s_tuser tdata: address[31:0]; tuser: func[1:0]
// m_*       out        m_tvalid/m_tready/m_tdata        tdata: hit, writeback, upgrade_miss
// cfg_*     in         cfg_valid/cfg_ready/cfg_data     cfg_data: coherence_mode[1:0]
//
// Per access, the beat is accepted while the set row is read, then the ways are
// compared, the row is written back and the flags load the output register. The row
// RAM read is registered, and accesses do not overlap: a new beat is not accepted
// until the lookup step is done.
// A full output register that is not drained holds the lookup step and the input.
// Reset clears one valid flag per set; a set whose flag is clear reads as empty.

module coherent_set_assoc_cache_ctrl
    import cscc_pkg::*;
#(
    parameter int OFFSET_BITS = 5,
    parameter int INDEX_BITS  = 6,
    parameter int WAYS        = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Access input.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,   // [31:0] address
    input  wire logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    // Result output.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [RES_W-1:0]  m_tdata,   // [0] hit, [1] writeback, [2] upgrade_miss
    // Mode register write.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MODE_W-1:0] cfg_data   // [1:0] coherence_mode
);

    // Geometry derived from the parameters.
    localparam int SETS   = 1 << INDEX_BITS;
    localparam int SET_W  = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_W  = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W = TAG_W + LSTAT_W + 1;
    localparam int ROW_W  = WAYS * LINE_W + WAY_W;

    // Controller states.
    localparam logic FSM_IDLE = 1'b0;
    localparam logic FSM_LOOK = 1'b1;

    logic              fsm_reg;
    logic              fsm_next;
    mode_t             mode_reg;
    logic [SETS-1:0]   row_valid_reg;
    logic              row_ok_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    func_t             func_reg;
    logic              m_tvalid_reg;
    logic [RES_W-1:0]  m_tdata_reg;

    logic [SET_W-1:0]  in_set;
    logic              in_fire;
    logic              done;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_next;
    logic [RES_W-1:0]  res_next;

    // Address split into set index and tag.
    if (INDEX_BITS > 0)
    begin : g_idx
        assign in_set = s_tdata[OFFSET_BITS +: INDEX_BITS];
    end
    else
    begin : g_noidx
        assign in_set = 1'b0;
    end

    assign s_tready  = (fsm_reg == FSM_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign done      = (fsm_reg == FSM_LOOK) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // One row per set: WAYS lines of {dirty, state, tag}, then the victim pointer.
    cscc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(SETS)
    ) u_row_ram (
        .clk  (clk),
        .we   (done),
        .waddr(set_reg),
        .wdata(row_next),
        .re   (in_fire),
        .raddr(in_set),
        .rdata(ram_rdata)
    );

    // Compare the ways and build the updated row and the result flags.
    always_comb
    begin
        logic [ROW_W-1:0]   row;
        logic [TAG_W-1:0]   ltag;
        lstat_t             lst;
        logic               found;
        logic [WAY_W-1:0]   hway;
        logic [WAY_W-1:0]   vway;
        logic [WAY_W-1:0]   uway;
        logic [LINE_W-1:0]  line;
        logic [TAG_W-1:0]   ntag;
        lstat_t             nst;
        logic               ndirty;
        logic               is_local;
        logic               is_msi;
        logic               is_vi;
        logic               upd;
        logic               hit;
        logic               wb;
        logic               upg;

        row      = ram_rdata & {ROW_W{row_ok_reg}};
        is_local = (func_reg == FN_LOAD) || (func_reg == FN_STORE);
        is_msi   = (mode_reg == MODE_MSI);
        is_vi    = (mode_reg == MODE_VI);
        found    = 1'b0;
        hway     = '0;
        hit      = 1'b0;
        wb       = 1'b0;
        upg      = 1'b0;
        upd      = 1'b0;
        uway     = '0;

        // Lowest matching way wins.
        for (int w = 0; w < WAYS; w++)
        begin
            ltag = row[w*LINE_W +: TAG_W];
            lst  = row[w*LINE_W + TAG_W +: LSTAT_W];
            if (!found && (ltag == tag_reg) &&
                (is_msi ? lst[1] : (lst == LS_VAL)))
            begin
                found = 1'b1;
                hway  = WAY_W'(w);
            end
        end

        vway   = row[WAYS*LINE_W +: WAY_W];
        line   = found ? row[hway*LINE_W +: LINE_W] : row[vway*LINE_W +: LINE_W];
        ntag   = line[TAG_W-1:0];
        nst    = line[TAG_W +: LSTAT_W];
        ndirty = line[LINE_W-1];

        if (found)
        begin
            hit  = 1'b1;
            upd  = 1'b1;
            uway = hway;
            if (is_msi)
            begin
                if (nst == LS_MOD)
                begin
                    if (func_reg == FN_STMISS)
                    begin
                        nst = LS_INV;
                        wb  = 1'b1;
                    end
                    else if (func_reg == FN_LDMISS)
                    begin
                        nst    = LS_SHR;
                        ndirty = 1'b0;
                        wb     = 1'b1;
                    end
                end
                else
                begin
                    if (func_reg == FN_STMISS)
                    begin
                        nst = LS_INV;
                    end
                    else if (func_reg == FN_STORE)
                    begin
                        nst    = LS_MOD;
                        ndirty = 1'b1;
                        hit    = 1'b0;
                        upg    = 1'b1;
                    end
                end
            end
            else if (is_local || is_vi)
            begin
                if (func_reg == FN_STORE)
                begin
                    ndirty = 1'b1;
                end
                else if (!is_local)
                begin
                    wb  = ndirty;
                    nst = LS_INV;
                end
            end
        end
        else if (is_local)
        begin
            // Fill the victim way; an occupied dirty line goes out first.
            upd    = 1'b1;
            uway   = vway;
            wb     = ndirty && (is_msi ? (nst != LS_INV) : (nst == LS_VAL));
            ntag   = tag_reg;
            nst    = is_msi ? ((func_reg == FN_STORE) ? LS_MOD : LS_SHR) : LS_VAL;
            ndirty = (func_reg == FN_STORE);
        end

        row_next = row;
        if (upd)
        begin
            row_next[uway*LINE_W +: LINE_W] = {ndirty, nst, ntag};
        end
        // Only local accesses advance the victim pointer.
        if (is_local)
        begin
            row_next[WAYS*LINE_W +: WAY_W] =
                (uway == WAY_W'(WAYS - 1)) ? '0 : WAY_W'(uway + 1'b1);
        end

        res_next          = '0;
        res_next[RES_HIT] = hit;
        res_next[RES_WB]  = wb;
        res_next[RES_UPG] = upg;
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    fsm_next = FSM_LOOK;
                end
            end
            FSM_LOOK:
            begin
                if (done)
                begin
                    fsm_next = FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= FSM_IDLE;
            mode_reg      <= MODE_NONE;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            row_ok_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (in_fire)
            begin
                row_ok_reg <= row_valid_reg[in_set];
            end
            if (done)
            begin
                row_valid_reg[set_reg] <= 1'b1;
                m_tvalid_reg           <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg  <= in_set;
            tag_reg  <= s_tdata[ADDR_W-1 -: TAG_W];
            func_reg <= s_tuser;
        end
        if (done)
        begin
            m_tdata_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

[design/cscc_checker.sv]
`default_nettype none

module cscc_checker
    import cscc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [RES_W-1:0] m_tdata,
    input wire logic             cfg_ready
);

    // A waiting result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An upgrade is never reported as a hit.
    a_upg_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[RES_HIT] && m_tdata[RES_UPG]))
        else $error("hit and upgrade_miss both set");

    // Unused result bits stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RES_W-1:RES_UPG+1] == '0))
        else $error("padding bits of result set");

    // The lookup step follows every accepted beat.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted during lookup");

    // Mode writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind coherent_set_assoc_cache_ctrl cscc_checker u_cscc_checker (.*);

`default_nettype wire
